// ----- sv/ymrr_pkg.sv -----
// ============================================================================
// ymrr_pkg: shared constants for the YUV macroblock/raster reorder unit
// Register indexes, plane codes, field widths and default size limits.
// ============================================================================
package ymrr_pkg;

    // Default limits on the frame size in macroblocks.
    localparam int DEF_MAX_MB_COLUMNS = 128;
    localparam int DEF_MAX_MB_ROWS    = 128;

    // Field widths of the ports.
    localparam int DIM_W      = 8;
    localparam int BASE_W     = 22;
    localparam int BLOCK_W    = 23;
    localparam int RASTER_W   = 21;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;

    // Width of the internal address arithmetic.
    localparam int ADDR_W     = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ILV    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 2'd3;

    // Plane codes.
    localparam logic [1:0] PLANE_Y  = 2'd0;
    localparam logic [1:0] PLANE_CB = 2'd1;
    localparam logic [1:0] PLANE_CR = 2'd2;

    // Block geometry.
    localparam logic [3:0] LUMA_LAST_ROW   = 4'd15;
    localparam logic [3:0] CHROMA_LAST_ROW = 4'd7;
    localparam logic [1:0] LUMA_LAST_WORD   = 2'd3;
    localparam logic [1:0] CHROMA_LAST_WORD = 2'd1;

endpackage

// ----- sv/yuv_macroblock_raster_reorder_unit.sv -----
// An accepted input item is registered in the first stage, then in the
// output register. Throughput: one item per cycle unless out_stall holds
// the output; the frame counters advance at accept and the address adds
// of the second stage need no iteration. Reset: counters clear to the
// first luma word; registers: 1x1 frame, separate chroma planes, base 0.
// ============================================================================
// yuv_macroblock_raster_reorder_unit
// Pairs each streamed data word with its word address in a macroblock
// ordered YUV 4:2:0 frame and in a raster ordered planar frame.
// ============================================================================
module yuv_macroblock_raster_reorder_unit #(
    parameter int MAX_MB_COLUMNS = ymrr_pkg::DEF_MAX_MB_COLUMNS,
    parameter int MAX_MB_ROWS    = ymrr_pkg::DEF_MAX_MB_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    // Configuration write channel.
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ymrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ymrr_pkg::BASE_W-1:0]       cfg_data,

    // Input item channel.
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              restart,
    input  logic [ymrr_pkg::DATA_W-1:0]       data_word,

    // Result item channel.
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ymrr_pkg::BLOCK_W-1:0]      block_order_address,
    output logic [ymrr_pkg::RASTER_W-1:0]     raster_address,
    output logic [ymrr_pkg::DATA_W-1:0]       word_out,
    output logic                              last_word
);

    // Counter widths and widths that can hold the limits themselves.
    localparam int CW  = (MAX_MB_COLUMNS > 1) ? $clog2(MAX_MB_COLUMNS) : 1;
    localparam int RW  = (MAX_MB_ROWS > 1) ? $clog2(MAX_MB_ROWS) : 1;
    localparam int DWC = $clog2(MAX_MB_COLUMNS + 1);
    localparam int DWR = $clog2(MAX_MB_ROWS + 1);
    localparam int LW  = RW + 4;
    localparam int AW  = ymrr_pkg::ADDR_W;

    // Configuration registers.
    logic [ymrr_pkg::DIM_W-1:0]  width_reg;
    logic [ymrr_pkg::DIM_W-1:0]  height_reg;
    logic                        ilv_reg;
    logic [ymrr_pkg::BASE_W-1:0] base_reg;

    // Frame counters.
    logic [1:0]    plane_reg;
    logic [RW-1:0] mb_row_reg;
    logic [CW-1:0] mb_col_reg;
    logic [3:0]    row_reg;
    logic [1:0]    word_reg;

    // First stage registers.
    logic                         s1_valid_reg;
    logic [1:0]                   s1_plane_reg;
    logic [CW-1:0]                s1_col_reg;
    logic [3:0]                   s1_row_reg;
    logic [1:0]                   s1_word_reg;
    logic                         s1_last_reg;
    logic [ymrr_pkg::DATA_W-1:0]  s1_data_reg;
    logic [RW+DWC-1:0]            s1_rw_reg;
    logic [LW+DWC-1:0]            s1_line_w_reg;
    logic [DWC+DWR-1:0]           s1_wh_reg;

    // Output registers.
    logic                          out_valid_reg;
    logic [ymrr_pkg::BLOCK_W-1:0]  block_reg;
    logic [ymrr_pkg::RASTER_W-1:0] raster_reg;
    logic [ymrr_pkg::DATA_W-1:0]   word_out_reg;
    logic                          last_reg;

    logic s2_ready;
    logic s1_ready;
    logic in_accept;

    logic [DWC-1:0] w_eff;
    logic [DWR-1:0] h_eff;

    logic [1:0]    plane_cur;
    logic [RW-1:0] mb_row_cur;
    logic [CW-1:0] mb_col_cur;
    logic [3:0]    row_cur;
    logic [1:0]    word_cur;
    logic [LW-1:0] line_cur;

    logic [1:0]    plane_next;
    logic [RW-1:0] mb_row_next;
    logic [CW-1:0] mb_col_next;
    logic [3:0]    row_next;
    logic [1:0]    word_next;
    logic          last_next;

    logic [3:0]     row_last;
    logic [1:0]     word_last;
    logic [DWC-1:0] col_inc;
    logic [DWR-1:0] mb_row_inc;

    logic [AW-1:0] mb_a;
    logic [AW-1:0] wh_a;
    logic [AW-1:0] start_a;
    logic [AW-1:0] y_a;
    logic [AW-1:0] x_a;
    logic [AW-1:0] line_c_a;
    logic [AW-1:0] blk_a;
    logic [AW-1:0] ras_a;
    logic [AW-1:0] block_sum;

    // Handshake: each stage moves on when the one after it can take an item.
    assign s2_ready  = !out_valid_reg || !out_stall;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;
    assign cfg_ready = 1'b1;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ymrr_pkg::DIM_W'(1);
            height_reg <= ymrr_pkg::DIM_W'(1);
            ilv_reg    <= 1'b0;
            base_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ymrr_pkg::CFG_WIDTH:  width_reg  <= cfg_data[ymrr_pkg::DIM_W-1:0];
                ymrr_pkg::CFG_HEIGHT: height_reg <= cfg_data[ymrr_pkg::DIM_W-1:0];
                ymrr_pkg::CFG_ILV:    ilv_reg    <= cfg_data[0];
                ymrr_pkg::CFG_BASE:   base_reg   <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Frame size with zero taken as one and large values held to the limit.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = DWC'(1);
        else if (9'(width_reg) > 9'(MAX_MB_COLUMNS))
            w_eff = DWC'(MAX_MB_COLUMNS);
        else
            w_eff = DWC'(width_reg);

        if (height_reg == '0)
            h_eff = DWR'(1);
        else if (9'(height_reg) > 9'(MAX_MB_ROWS))
            h_eff = DWR'(MAX_MB_ROWS);
        else
            h_eff = DWR'(height_reg);
    end

    // Counter values for this item, after an optional restart.
    always_comb
    begin
        plane_cur  = restart ? ymrr_pkg::PLANE_Y : plane_reg;
        mb_row_cur = restart ? '0 : mb_row_reg;
        mb_col_cur = restart ? '0 : mb_col_reg;
        row_cur    = restart ? '0 : row_reg;
        word_cur   = restart ? '0 : word_reg;

        // Pixel line within the plane: 16 lines per macroblock row for luma,
        // 8 for chroma.
        if (plane_cur == ymrr_pkg::PLANE_Y)
            line_cur = {mb_row_cur, row_cur};
        else
            line_cur = LW'({mb_row_cur, row_cur[2:0]}) + LW'(row_cur[3]) * LW'(8);
    end

    // Counter advance: word, row, column, macroblock row, then plane.
    always_comb
    begin
        row_last   = (plane_cur == ymrr_pkg::PLANE_Y) ? ymrr_pkg::LUMA_LAST_ROW
                                                      : ymrr_pkg::CHROMA_LAST_ROW;
        word_last  = (plane_cur == ymrr_pkg::PLANE_Y) ? ymrr_pkg::LUMA_LAST_WORD
                                                      : ymrr_pkg::CHROMA_LAST_WORD;
        col_inc    = DWC'(mb_col_cur) + DWC'(1);
        mb_row_inc = DWR'(mb_row_cur) + DWR'(1);

        plane_next  = plane_cur;
        mb_row_next = mb_row_cur;
        mb_col_next = mb_col_cur;
        row_next    = row_cur;
        word_next   = word_cur;
        last_next   = 1'b0;

        if (word_cur < word_last)
        begin
            word_next = word_cur + 2'd1;
        end
        else
        begin
            word_next = '0;
            if (row_cur < row_last)
            begin
                row_next = row_cur + 4'd1;
            end
            else
            begin
                row_next = '0;
                if (col_inc < w_eff)
                begin
                    mb_col_next = col_inc[CW-1:0];
                end
                else
                begin
                    mb_col_next = '0;
                    if (mb_row_inc < h_eff)
                    begin
                        mb_row_next = mb_row_inc[RW-1:0];
                    end
                    else
                    begin
                        mb_row_next = '0;
                        if (plane_cur < ymrr_pkg::PLANE_CR)
                        begin
                            plane_next = plane_cur + 2'd1;
                        end
                        else
                        begin
                            plane_next = ymrr_pkg::PLANE_Y;
                            last_next  = 1'b1;
                        end
                    end
                end
            end
        end
    end

    // Counter registers advance at each accepted item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg  <= ymrr_pkg::PLANE_Y;
            mb_row_reg <= '0;
            mb_col_reg <= '0;
            row_reg    <= '0;
            word_reg   <= '0;
        end
        else if (in_accept)
        begin
            plane_reg  <= plane_next;
            mb_row_reg <= mb_row_next;
            mb_col_reg <= mb_col_next;
            row_reg    <= row_next;
            word_reg   <= word_next;
        end
    end

    // First stage valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    // First stage payload: counters and the three small products.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_plane_reg  <= plane_cur;
            s1_col_reg    <= mb_col_cur;
            s1_row_reg    <= row_cur;
            s1_word_reg   <= word_cur;
            s1_last_reg   <= last_next;
            s1_data_reg   <= data_word;
            s1_rw_reg     <= (RW+DWC)'(mb_row_cur) * (RW+DWC)'(w_eff);
            s1_line_w_reg <= (LW+DWC)'(line_cur) * (LW+DWC)'(w_eff);
            s1_wh_reg     <= (DWC+DWR)'(w_eff) * (DWC+DWR)'(h_eff);
        end
    end

    // Second stage: address offsets from the registered products.
    always_comb
    begin
        mb_a     = AW'(s1_rw_reg) + AW'(s1_col_reg);
        wh_a     = AW'(s1_wh_reg);
        y_a      = AW'(s1_row_reg);
        x_a      = AW'(s1_word_reg);
        line_c_a = AW'(s1_line_w_reg) + AW'(s1_col_reg);

        // Chroma plane start: Cb after the luma plane, Cr a quarter plane later.
        if (s1_plane_reg == ymrr_pkg::PLANE_CR)
            start_a = (wh_a << 6) + (wh_a << 4);
        else
            start_a = wh_a << 6;

        if (s1_plane_reg == ymrr_pkg::PLANE_Y)
        begin
            blk_a = (mb_a << 6) + (y_a << 2) + x_a;
            ras_a = (line_c_a << 2) + x_a;
        end
        else
        begin
            if (ilv_reg)
                blk_a = (wh_a << 6) + (mb_a << 5)
                      + ((s1_plane_reg == ymrr_pkg::PLANE_CR) ? AW'(16) : AW'(0))
                      + (y_a << 1) + x_a;
            else
                blk_a = start_a + (mb_a << 4) + (y_a << 1) + x_a;
            ras_a = start_a + (line_c_a << 1) + x_a;
        end

        block_sum = AW'(base_reg) + blk_a;
    end

    // Output register, which holds the item while the receiver stalls.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_ready)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            block_reg    <= block_sum[ymrr_pkg::BLOCK_W-1:0];
            raster_reg   <= ras_a[ymrr_pkg::RASTER_W-1:0];
            word_out_reg <= s1_data_reg;
            last_reg     <= s1_last_reg;
        end
    end

    assign out_valid           = out_valid_reg;
    assign block_order_address = block_reg;
    assign raster_address      = raster_reg;
    assign word_out            = word_out_reg;
    assign last_word           = last_reg;

endmodule

// ----- test/reorder_address_checker.sv -----
`timescale 1ns / 1ps
// ============================================================================
// reorder_address_checker: scoreboard for the YUV macroblock/raster reorder
// Tracks register writes and accepted input items, predicts the address pair
// of every word from its own copy of the frame counters, and compares each
// accepted result item with the oldest prediction.
// ============================================================================
module reorder_address_checker #(
    parameter int MAX_MB_COLUMNS = ymrr_pkg::DEF_MAX_MB_COLUMNS,
    parameter int MAX_MB_ROWS    = ymrr_pkg::DEF_MAX_MB_ROWS
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [ymrr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ymrr_pkg::BASE_W-1:0]       cfg_data,

    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              restart,
    input  logic [ymrr_pkg::DATA_W-1:0]       data_word,

    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [ymrr_pkg::BLOCK_W-1:0]      block_order_address,
    input  logic [ymrr_pkg::RASTER_W-1:0]     raster_address,
    input  logic [ymrr_pkg::DATA_W-1:0]       word_out,
    input  logic                              last_word,

    output int                                mismatches,
    output int                                outstanding
);

    typedef struct packed {
        logic [ymrr_pkg::BLOCK_W-1:0]  block_addr;
        logic [ymrr_pkg::RASTER_W-1:0] raster_addr;
        logic [ymrr_pkg::DATA_W-1:0]   word;
        logic                          last;
    } placement_t;

    // Shadow copy of the registers.
    logic [ymrr_pkg::DIM_W-1:0]  width_reg;
    logic [ymrr_pkg::DIM_W-1:0]  height_reg;
    logic                        ilv_reg;
    logic [ymrr_pkg::BASE_W-1:0] base_reg;

    // Shadow copy of the frame counters.
    logic [1:0] plane;
    logic [6:0] mb_row;
    logic [6:0] mb_col;
    logic [3:0] row_pos;
    logic [1:0] word_pos;

    placement_t pending_placements[$];
    int         errors;

    // A zero dimension counts as one macroblock, an oversized one as the maximum.
    function automatic int unsigned span(input logic [ymrr_pkg::DIM_W-1:0] v,
                                         input int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return v;
    endfunction

    // Works out both addresses of one word and advances the frame counters.
    function automatic placement_t place_word(input logic rs,
                                              input logic [ymrr_pkg::DATA_W-1:0] word);
        int unsigned w, h, r, c, y, x, mb, k, start, blk, ras, sum;
        logic [3:0]  last_row;
        logic [1:0]  last_col;
        placement_t  p;
        w = span(width_reg, MAX_MB_COLUMNS);
        h = span(height_reg, MAX_MB_ROWS);
        if (rs)
        begin
            plane    = ymrr_pkg::PLANE_Y;
            mb_row   = '0;
            mb_col   = '0;
            row_pos  = '0;
            word_pos = '0;
        end
        r  = mb_row;
        c  = mb_col;
        y  = row_pos;
        x  = word_pos;
        mb = r * w + c;

        if (plane == ymrr_pkg::PLANE_Y)
        begin
            blk      = mb * 64 + y * 4 + x;
            ras      = (r * 16 + y) * w * 4 + c * 4 + x;
            last_row = ymrr_pkg::LUMA_LAST_ROW;
            last_col = ymrr_pkg::LUMA_LAST_WORD;
        end
        else
        begin
            k     = (plane == ymrr_pkg::PLANE_CR) ? 1 : 0;
            start = w * h * (64 + 16 * k);
            if (ilv_reg)
                blk = w * h * 64 + mb * 32 + k * 16 + y * 2 + x;
            else
                blk = start + mb * 16 + y * 2 + x;
            ras      = start + (r * 8 + y) * w * 2 + c * 2 + x;
            last_row = ymrr_pkg::CHROMA_LAST_ROW;
            last_col = ymrr_pkg::CHROMA_LAST_WORD;
        end

        sum           = base_reg + blk;
        p.block_addr  = sum[ymrr_pkg::BLOCK_W-1:0];
        p.raster_addr = ras[ymrr_pkg::RASTER_W-1:0];
        p.word        = word;
        p.last        = 1'b0;

        // Advance word, row, column, macroblock row and plane in turn.
        if (x < last_col)
            word_pos = word_pos + 1'b1;
        else
        begin
            word_pos = '0;
            if (y < last_row)
                row_pos = row_pos + 1'b1;
            else
            begin
                row_pos = '0;
                if (c + 1 < w)
                    mb_col = mb_col + 1'b1;
                else
                begin
                    mb_col = '0;
                    if (r + 1 < h)
                        mb_row = mb_row + 1'b1;
                    else
                    begin
                        mb_row = '0;
                        if (plane == ymrr_pkg::PLANE_CR)
                        begin
                            plane  = ymrr_pkg::PLANE_Y;
                            p.last = 1'b1;
                        end
                        else
                            plane = plane + 1'b1;
                    end
                end
            end
        end
        return p;
    endfunction

    task automatic check_field(input string name, input logic [ymrr_pkg::DATA_W-1:0] want,
                               input logic [ymrr_pkg::DATA_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endtask

    // Watch all three channels at each clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            width_reg   = 8'd1;
            height_reg  = 8'd1;
            ilv_reg     = 1'b0;
            base_reg    = '0;
            plane       = ymrr_pkg::PLANE_Y;
            mb_row      = '0;
            mb_col      = '0;
            row_pos     = '0;
            word_pos    = '0;
            errors      = 0;
            pending_placements.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ymrr_pkg::CFG_WIDTH:  width_reg  = cfg_data[ymrr_pkg::DIM_W-1:0];
                    ymrr_pkg::CFG_HEIGHT: height_reg = cfg_data[ymrr_pkg::DIM_W-1:0];
                    ymrr_pkg::CFG_ILV:    ilv_reg    = cfg_data[0];
                    ymrr_pkg::CFG_BASE:   base_reg   = cfg_data;
                    default:              ;
                endcase
            end

            if (in_valid && !in_stall)
                pending_placements.push_back(place_word(restart, data_word));

            if (out_valid && !out_stall)
            begin
                if (pending_placements.size() == 0)
                begin
                    $error("result item arrived with no expectation waiting");
                    errors++;
                end
                else
                begin
                    want = pending_placements.pop_front();
                    check_field("block_order_address",
                                ymrr_pkg::DATA_W'(want.block_addr),
                                ymrr_pkg::DATA_W'(block_order_address));
                    check_field("raster_address",
                                ymrr_pkg::DATA_W'(want.raster_addr),
                                ymrr_pkg::DATA_W'(raster_address));
                    check_field("word_out", want.word, word_out);
                    check_field("last_word", ymrr_pkg::DATA_W'(want.last),
                                ymrr_pkg::DATA_W'(last_word));
                end
            end

            mismatches  <= errors;
            outstanding <= pending_placements.size();
        end
    end

endmodule

// ----- test/yuv_macroblock_raster_reorder_unit_tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// yuv_macroblock_raster_reorder_unit_tb: stimulus and verdict
// Streams data words through the reorder unit under a series of frame
// settings, with random gaps and output stalls and one long output hold,
// while the checker predicts and compares every address pair.
// ============================================================================
module yuv_macroblock_raster_reorder_unit_tb;

    localparam int RANDOM_WORDS  = 850;
    localparam int HOLD_AT_WORD  = 400;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 10;
    localparam int LIMIT_CYCLES  = 500000;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ymrr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ymrr_pkg::BASE_W-1:0]    cfg_data;
    logic                           in_valid;
    logic                           in_stall;
    logic                           restart;
    logic [ymrr_pkg::DATA_W-1:0]    data_word;
    logic                           out_valid;
    logic                           out_stall;
    logic [ymrr_pkg::BLOCK_W-1:0]   block_order_address;
    logic [ymrr_pkg::RASTER_W-1:0]  raster_address;
    logic [ymrr_pkg::DATA_W-1:0]    word_out;
    logic                           last_word;

    int mismatches;
    int outstanding;
    int accepted_words;
    int cycle_count;
    bit no_gaps;

    yuv_macroblock_raster_reorder_unit dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .restart             (restart),
        .data_word           (data_word),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .block_order_address (block_order_address),
        .raster_address      (raster_address),
        .word_out            (word_out),
        .last_word           (last_word)
    );

    reorder_address_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .restart             (restart),
        .data_word           (data_word),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .block_order_address (block_order_address),
        .raster_address      (raster_address),
        .word_out            (word_out),
        .last_word           (last_word),
        .mismatches          (mismatches),
        .outstanding         (outstanding)
    );

    // 50 MHz clock.
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // No gap half the time, otherwise mostly short gaps and now and then a long one.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly small frames, with zero, oversized and maximum dimensions mixed in.
    function automatic logic [ymrr_pkg::DIM_W-1:0] pick_dim();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 8'd1;
        if (pick < 65)
            return 8'd2;
        if (pick < 75)
            return 8'd3;
        if (pick < 83)
            return 8'd0;
        if (pick < 91)
            return ymrr_pkg::DIM_W'($urandom_range(129, 255));
        return 8'd128;
    endfunction

    task automatic write_reg(input logic [ymrr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ymrr_pkg::BASE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Offers one item after an optional gap and returns at the edge that takes it.
    task automatic push_word(input logic rs, input logic [ymrr_pkg::DATA_W-1:0] word);
        int gap;
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        restart   <= rs;
        data_word <= word;
        do
            @(posedge clk);
        while (in_stall);
        accepted_words++;
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Output side: random stalls, plus one long hold that backs up the input.
    initial
    begin
        int  gap;
        bit  held;
        held = 1'b0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && accepted_words >= HOLD_AT_WORD)
            begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 60 : 8)) @(posedge clk);
            gap = idle_len();
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int random_words;
        int n;
        bit first_phase;
        logic rs;

        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= ymrr_pkg::CFG_WIDTH;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        data_word <= '0;
        accepted_words = 0;
        no_gaps = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero dimensions behave as a single macroblock.
        write_reg(ymrr_pkg::CFG_WIDTH, '0);
        write_reg(ymrr_pkg::CFG_HEIGHT, '0);
        push_word(1'b1, 32'h0000_0000);
        push_word(1'b0, 32'hFFFF_FFFF);
        push_word(1'b0, 32'h5A5A_A5A5);

        // Oversized dimensions, interleaved chroma and the top base, changed mid-frame.
        wait_idle();
        write_reg(ymrr_pkg::CFG_WIDTH, 22'd255);
        write_reg(ymrr_pkg::CFG_HEIGHT, 22'd200);
        write_reg(ymrr_pkg::CFG_ILV, 22'd1);
        write_reg(ymrr_pkg::CFG_BASE, 22'h3F_FFFF);
        repeat (4) push_word(1'b0, $urandom());

        // Exact maximum frame size, with a restart in the middle of the stream.
        wait_idle();
        write_reg(ymrr_pkg::CFG_WIDTH, 22'd128);
        write_reg(ymrr_pkg::CFG_HEIGHT, 22'd128);
        repeat (3) push_word(1'b0, $urandom());
        push_word(1'b1, 32'hFFFF_FFFF);
        push_word(1'b0, 32'h0000_0000);
        push_word(1'b0, $urandom());

        // Random phases: new settings between phases, frames often left unfinished.
        random_words = 0;
        first_phase  = 1'b1;
        while (random_words < RANDOM_WORDS)
        begin
            wait_idle();
            if (first_phase || $urandom_range(0, 1))
                write_reg(ymrr_pkg::CFG_WIDTH, ymrr_pkg::BASE_W'(pick_dim()));
            if (first_phase || $urandom_range(0, 1))
                write_reg(ymrr_pkg::CFG_HEIGHT, ymrr_pkg::BASE_W'(pick_dim()));
            if (first_phase || $urandom_range(0, 1))
                write_reg(ymrr_pkg::CFG_ILV, ymrr_pkg::BASE_W'($urandom_range(0, 1)));
            if (first_phase || $urandom_range(0, 1))
                write_reg(ymrr_pkg::CFG_BASE, ymrr_pkg::BASE_W'(($urandom_range(0, 3) == 0) ?
                          (($urandom_range(0, 1) != 0) ? 22'h3F_FFFF : 22'h0) :
                          $urandom_range(0, 22'h3F_FFFF)));
            first_phase = 1'b0;
            no_gaps = ($urandom_range(0, 3) == 0);
            n = $urandom_range(40, 160);
            if (n > RANDOM_WORDS - random_words)
                n = RANDOM_WORDS - random_words;
            for (int i = 0; i < n; i++)
            begin
                rs = (i == 0 && $urandom_range(0, 1) != 0) || ($urandom_range(0, 199) == 0);
                push_word(rs, ($urandom_range(0, 15) == 0) ?
                          (($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0) :
                          $urandom());
                random_words++;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- yuv_macroblock_raster_reorder_unit.f -----
sv/ymrr_pkg.sv
sv/yuv_macroblock_raster_reorder_unit.sv
test/reorder_address_checker.sv
test/yuv_macroblock_raster_reorder_unit_tb.sv
